@@ rtl/chr_pkg.sv @@
// ----------------------------------------------------------------------------
// chr_pkg: shared types, constants and hash helpers for the hash ring
// Holds the controller/datapath command and status words, the result codes
// and the FNV-1a byte step and finishing mix.
// ----------------------------------------------------------------------------
`default_nettype none

package chr_pkg;

  localparam int unsigned RING_DEPTH = 512;
  localparam int unsigned NODE_COUNT = 16;
  localparam int unsigned AW         = $clog2(RING_DEPTH);
  localparam int unsigned CW         = $clog2(RING_DEPTH + 1);
  localparam int unsigned NW         = $clog2(NODE_COUNT);
  localparam int unsigned NCW        = $clog2(NODE_COUNT + 1);
  localparam int unsigned VW         = 10;
  localparam int unsigned HW         = 32;

  localparam logic [HW-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [HW-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [VW-1:0] VPN_RESET = 10'd32;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [2:0] FIN_LAST = 3'd5;
  localparam logic [2:0] SFX_FIX  = 3'd3;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_ADDED   = 3'd2,
    ST_DUP     = 3'd3,
    ST_REMOVED = 3'd4,
    ST_FAIL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FOP_HOLD,
    FOP_LOAD,
    FOP_SFX,
    FOP_FIN
  } fin_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIN_K,
    S_DISPATCH,
    S_VN_CHK,
    S_SFX,
    S_FIN_V,
    S_SCAN_V,
    S_APPLY,
    S_SCAN_LK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     clr_en;
    fin_op_e  fin_op;
    logic [2:0] step;
    logic     key_save;
    logic     scan_clr;
    logic     scan_en;
    logic     node_set;
    logic     node_clr;
    logic     vn_clr;
    logic     vn_inc;
    logic     apply_add;
    logic     apply_rem;
    logic     res_load;
    status_e  res_status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic node_here;
    logic vn_done;
    logic sfx_last;
  } sts_t;

  function automatic logic [HW-1:0] fnv_byte(logic [HW-1:0] h, logic [7:0] b);
    logic [HW-1:0] x;
    x = h ^ {{24{b[7]}}, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic [HW-1:0] fin_step(logic [HW-1:0] h, logic [2:0] k);
    logic [HW-1:0] r;
    unique case (k)
      3'd0:    r = h + (h << 13);
      3'd1:    r = h ^ HW'($signed(h) >>> 7);
      3'd2:    r = h + (h << 3);
      3'd3:    r = h ^ HW'($signed(h) >>> 17);
      3'd4:    r = h + (h << 5);
      3'd5:    r = h[HW-1] ? (HW'(0) - h) : h;
      default: r = h;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/chr_dp.sv @@
// ----------------------------------------------------------------------------
// chr_dp: hash ring datapath
// Running FNV-1a hash, shared finishing unit, virtual-node suffix generator,
// ring memory with a one-entry-per-cycle scan, presence bits and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module chr_dp (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  chr_pkg::cmd_t            cmd_i,
  output chr_pkg::sts_t            sts_o,
  input  wire  [7:0]               key_byte_i,
  input  wire                      byte_present_i,
  input  wire                      last_byte_i,
  input  wire  [chr_pkg::NW-1:0]   node_number_i,
  input  wire                      cfg_valid_i,
  input  wire  [chr_pkg::VW-1:0]   cfg_data_i,
  output logic [chr_pkg::NW-1:0]   owner_node_o,
  output logic [2:0]               status_o,
  output logic [chr_pkg::HW-1:0]   key_hash_o,
  output logic [chr_pkg::CW-1:0]   ring_points_o,
  output logic [chr_pkg::NCW-1:0]  nodes_present_o
);
  import chr_pkg::*;

  localparam int unsigned MW = 1 + HW + NW;

  logic [HW-1:0] run_q, name_q, fin_q, key_q;
  logic [HW-1:0] fnv_in, fin_nx;
  logic [NW-1:0] node_q;
  logic [VW-1:0] vpn_q, vidx_q;
  logic [3:0]    bcd_q [4];
  logic [3:0]    bcd_d [4];
  logic [2:0]    nd;
  logic [1:0]    dsel;
  logic [7:0]    sfx_byte;
  logic          carry;

  logic [MW-1:0] mem_q [RING_DEPTH];
  logic [MW-1:0] rd_q;
  logic          rdv_q;
  logic [AW-1:0] rd_idx_q;
  logic [CW-1:0] scan_q;
  logic          scan_issue, clr_wr;

  logic          we;
  logic [AW-1:0] wa;
  logic [MW-1:0] wd;

  logic          best_v_q, least_v_q, match_q, free_q, err_q;
  logic [HW-1:0] best_h_q, least_h_q;
  logic [NW-1:0] best_o_q, least_o_q;
  logic [AW-1:0] match_idx_q, free_idx_q;
  logic [CW-1:0] count_q;
  logic [NODE_COUNT-1:0] nodes_q;

  logic          rd_v;
  logic [HW-1:0] rd_h;
  logic [NW-1:0] rd_o;
  logic          upd_least, upd_best, hit, first_free;

  logic [NW-1:0] owner_q;
  status_e       status_q;

  // Hash front end
  assign fnv_in = byte_present_i ? fnv_byte(run_q, key_byte_i) : run_q;
  assign fin_nx = fin_step(fin_q, cmd_i.step);

  // Decimal digits of the virtual index, most significant first
  always_comb begin
    if (bcd_q[3] != 4'd0)      nd = 3'd4;
    else if (bcd_q[2] != 4'd0) nd = 3'd3;
    else if (bcd_q[1] != 4'd0) nd = 3'd2;
    else                       nd = 3'd1;
  end

  assign dsel = 2'(nd - 3'd1 - (cmd_i.step - SFX_FIX));

  always_comb begin
    unique case (cmd_i.step)
      3'd0:    sfx_byte = CH_HASH;
      3'd1:    sfx_byte = CH_V;
      3'd2:    sfx_byte = CH_N;
      default: sfx_byte = CH_ZERO | {4'h0, bcd_q[dsel]};
    endcase
  end

  always_comb begin
    carry = 1'b1;
    for (int k = 0; k < 4; k++) begin
      bcd_d[k] = bcd_q[k];
      if (carry) begin
        if (bcd_q[k] == 4'd9) begin
          bcd_d[k] = 4'd0;
        end else begin
          bcd_d[k] = bcd_q[k] + 4'd1;
          carry    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= FNV_BASIS;
      vpn_q <= VPN_RESET;
    end else begin
      if (cmd_i.accept) begin
        run_q <= last_byte_i ? FNV_BASIS : fnv_in;
      end
      if (cfg_valid_i) begin
        vpn_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_byte_i) begin
      name_q <= fnv_in;
      fin_q  <= fnv_in;
      node_q <= node_number_i;
    end else begin
      unique case (cmd_i.fin_op)
        FOP_LOAD: fin_q <= name_q;
        FOP_SFX:  fin_q <= fnv_byte(fin_q, sfx_byte);
        FOP_FIN:  fin_q <= fin_nx;
        default:  fin_q <= fin_q;
      endcase
    end
    if (cmd_i.key_save) begin
      key_q <= fin_nx;
    end
    if (cmd_i.vn_clr) begin
      for (int k = 0; k < 4; k++) bcd_q[k] <= 4'd0;
    end else if (cmd_i.vn_inc) begin
      bcd_q <= bcd_d;
    end
  end

  // Ring memory: clearing pass, scan reads and end-of-scan updates share it
  assign clr_wr     = cmd_i.clr_en && (scan_q != CW'(RING_DEPTH));
  assign scan_issue = cmd_i.scan_en && (scan_q != CW'(RING_DEPTH));

  always_comb begin
    we = 1'b0;
    wa = scan_q[AW-1:0];
    wd = '0;
    priority if (clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.apply_add && !match_q && free_q) begin
      we = 1'b1;
      wa = free_idx_q;
      wd = {1'b1, fin_q, node_q};
    end else if (cmd_i.apply_rem && match_q) begin
      we = 1'b1;
      wa = match_idx_q;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q     <= mem_q[scan_q[AW-1:0]];
    rd_idx_q <= scan_q[AW-1:0];
  end

  assign rd_v = rd_q[MW-1];
  assign rd_h = rd_q[NW +: HW];
  assign rd_o = rd_q[NW-1:0];

  assign upd_least  = rdv_q && rd_v &&
                      (!least_v_q || ($signed(rd_h) < $signed(least_h_q)));
  assign upd_best   = rdv_q && rd_v && ($signed(rd_h) >= $signed(key_q)) &&
                      (!best_v_q || ($signed(rd_h) < $signed(best_h_q)));
  assign hit        = rdv_q && rd_v && (rd_h == fin_q);
  assign first_free = rdv_q && !rd_v && !free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      rdv_q     <= 1'b0;
      best_v_q  <= 1'b0;
      least_v_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      err_q     <= 1'b0;
      count_q   <= '0;
      nodes_q   <= '0;
      vidx_q    <= '0;
    end else begin
      rdv_q <= scan_issue;
      if (cmd_i.scan_clr) begin
        scan_q    <= '0;
        best_v_q  <= 1'b0;
        least_v_q <= 1'b0;
        match_q   <= 1'b0;
        free_q    <= 1'b0;
      end else begin
        if (scan_issue || clr_wr) scan_q <= scan_q + CW'(1);
        if (upd_least)  least_v_q <= 1'b1;
        if (upd_best)   best_v_q  <= 1'b1;
        if (hit)        match_q   <= 1'b1;
        if (first_free) free_q    <= 1'b1;
      end
      if (cmd_i.vn_clr) begin
        err_q  <= 1'b0;
        vidx_q <= '0;
      end else if (cmd_i.vn_inc) begin
        vidx_q <= vidx_q + VW'(1);
      end
      if (cmd_i.apply_add && !match_q) begin
        if (free_q) count_q <= count_q + CW'(1);
        else        err_q   <= 1'b1;
      end
      if (cmd_i.apply_rem && match_q) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.node_set) nodes_q[node_q] <= 1'b1;
      if (cmd_i.node_clr) nodes_q[node_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_least) begin
      least_h_q <= rd_h;
      least_o_q <= rd_o;
    end
    if (upd_best) begin
      best_h_q <= rd_h;
      best_o_q <= rd_o;
    end
    if (hit)        match_idx_q <= rd_idx_q;
    if (first_free) free_idx_q  <= rd_idx_q;
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_status)
        ST_FOUND: begin
          status_q <= least_v_q ? ST_FOUND : ST_EMPTY;
          if (best_v_q)       owner_q <= best_o_q;
          else if (least_v_q) owner_q <= least_o_q;
          else                owner_q <= '0;
        end
        ST_ADDED: begin
          status_q <= err_q ? ST_FAIL : ST_ADDED;
          owner_q  <= node_q;
        end
        default: begin
          status_q <= cmd_i.res_status;
          owner_q  <= node_q;
        end
      endcase
    end
  end

  assign owner_node_o    = owner_q;
  assign status_o        = status_q;
  assign key_hash_o      = key_q;
  assign ring_points_o   = count_q;
  assign nodes_present_o = NCW'($countones(nodes_q));

  assign sts_o.clr_done  = (scan_q == CW'(RING_DEPTH));
  assign sts_o.scan_done = (scan_q == CW'(RING_DEPTH)) && !rdv_q;
  assign sts_o.node_here = nodes_q[node_q];
  assign sts_o.vn_done   = (vidx_q == vpn_q);
  assign sts_o.sfx_last  = (cmd_i.step == 3'(nd + 3'd2));

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RING_DEPTH))
    else $error("ring point count beyond depth");

  a_erase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply_rem && match_q |=> count_q == $past(count_q) - CW'(1))
    else $error("erase did not drop the point count");

endmodule

`default_nettype wire

@@ rtl/chr_ctrl.sv @@
// ----------------------------------------------------------------------------
// chr_ctrl: hash ring sequencer
// Walks each operation through key finishing, per-virtual-node hashing,
// ring scans and updates, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module chr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire                 last_byte_i,
  input  wire  [1:0]          action_i,
  input  chr_pkg::sts_t       sts_i,
  output chr_pkg::cmd_t       cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import chr_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] act_q, act_d;
  logic       is_add, is_rem;

  assign is_add = (act_q == ACT_ADD);
  assign is_rem = (act_q == ACT_REMOVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= '0;
      act_q   <= ACT_LOOKUP;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      act_q   <= act_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    act_d   = act_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i && last_byte_i) begin
          act_d   = action_i;
          step_d  = '0;
          state_d = S_FIN_K;
        end
      end
      S_FIN_K: begin
        if (step_q == FIN_LAST) begin
          step_d  = '0;
          state_d = S_DISPATCH;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_DISPATCH: begin
        if (is_add)      state_d = sts_i.node_here ? S_OUT : S_VN_CHK;
        else if (is_rem) state_d = sts_i.node_here ? S_VN_CHK : S_OUT;
        else             state_d = S_SCAN_LK;
      end
      S_VN_CHK: begin
        step_d  = '0;
        state_d = sts_i.vn_done ? S_OUT : S_SFX;
      end
      S_SFX: begin
        if (sts_i.sfx_last) begin
          step_d  = '0;
          state_d = S_FIN_V;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_FIN_V: begin
        if (step_q == FIN_LAST) begin
          step_d  = '0;
          state_d = S_SCAN_V;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_SCAN_V:  if (sts_i.scan_done) state_d = S_APPLY;
      S_APPLY:   state_d = S_VN_CHK;
      S_SCAN_LK: if (sts_i.scan_done) state_d = S_OUT;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.fin_op     = FOP_HOLD;
    cmd_o.step       = step_q;
    cmd_o.res_status = ST_FOUND;
    busy_o           = (state_q != S_IDLE);
    done_o           = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_en = 1'b1;
      S_IDLE:  cmd_o.accept = start_i;
      S_FIN_K: begin
        cmd_o.fin_op   = FOP_FIN;
        cmd_o.key_save = (step_q == FIN_LAST);
      end
      S_DISPATCH: begin
        if (is_add) begin
          if (sts_i.node_here) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_DUP;
          end else begin
            cmd_o.node_set = 1'b1;
            cmd_o.vn_clr   = 1'b1;
          end
        end else if (is_rem) begin
          if (sts_i.node_here) begin
            cmd_o.node_clr = 1'b1;
            cmd_o.vn_clr   = 1'b1;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_FAIL;
          end
        end else begin
          cmd_o.scan_clr = 1'b1;
        end
      end
      S_VN_CHK: begin
        if (sts_i.vn_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = is_add ? ST_ADDED : ST_REMOVED;
        end else begin
          cmd_o.fin_op = FOP_LOAD;
        end
      end
      S_SFX: cmd_o.fin_op = FOP_SFX;
      S_FIN_V: begin
        cmd_o.fin_op   = FOP_FIN;
        cmd_o.scan_clr = (step_q == FIN_LAST);
      end
      S_SCAN_V: cmd_o.scan_en = 1'b1;
      S_APPLY: begin
        cmd_o.apply_add = is_add;
        cmd_o.apply_rem = is_rem;
        cmd_o.vn_inc    = 1'b1;
      end
      S_SCAN_LK: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.res_load   = sts_i.scan_done;
        cmd_o.res_status = ST_FOUND;
      end
      S_OUT:   done_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_load_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> done_o)
    else $error("result loaded without a strobe next cycle");

endmodule

`default_nettype wire

@@ rtl/consistent_hash_ring.sv @@
// ----------------------------------------------------------------------------
// consistent_hash_ring: consistent-hash ring, FNV-1a keys and virtual nodes
// Streams key or node-name bytes and performs lookup, add or remove on the
// final byte of each string.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are accepted when start is high and busy is low. A word
//   that is not the last byte is only folded into the hash; busy stays low.
//   On the last byte the operation runs and one result word appears for a
//   single cycle with done_o high; the receiver cannot stall it.
//   Lookup: the key hash is finished, the operation is dispatched, the whole
//   ring is scanned and the result word is loaded. Add of a present node or
//   remove of an absent one goes from dispatch straight to the result.
//   Add/remove: after key finishing and dispatch, per virtual node, a check
//   step, the suffix bytes (4 to 7), the finishing mix, one ring scan and
//   one update step; a final check loads the result. The single-port ring
//   memory is read one entry per cycle in every scan.
//   virtual_per_node is written through cfg_valid_i/cfg_data_i; the user must
//   write it only while idle, as the block does not enforce this itself.
//   cfg_ready_o is always high. After reset the block clears the 512-entry
//   ring, one entry a cycle, and holds busy high until the clearing is done.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               action_i,
  input  wire  [7:0]               key_byte_i,
  input  wire                      byte_present_i,
  input  wire                      last_byte_i,
  input  wire  [chr_pkg::NW-1:0]   node_number_i,
  output logic                     done_o,
  output logic [chr_pkg::NW-1:0]   owner_node_o,
  output logic [2:0]               status_o,
  output logic [chr_pkg::HW-1:0]   key_hash_o,
  output logic [chr_pkg::CW-1:0]   ring_points_o,
  output logic [chr_pkg::NCW-1:0]  nodes_present_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [chr_pkg::VW-1:0]   cfg_data_i
);
  import chr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  chr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_byte_i (last_byte_i),
    .action_i    (action_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .done_o      (done_o)
  );

  chr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .key_byte_i      (key_byte_i),
    .byte_present_i  (byte_present_i),
    .last_byte_i     (last_byte_i),
    .node_number_i   (node_number_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .owner_node_o    (owner_node_o),
    .status_o        (status_o),
    .key_hash_o      (key_hash_o),
    .ring_points_o   (ring_points_o),
    .nodes_present_o (nodes_present_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_consistent_hash_ring.sv @@
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring: self-checking bench for the consistent hash ring
// Streams key and node-name words into the ring, mirrors the ring contents,
// the node presence bits and the running FNV-1a hash in a local model, and
// compares every result word field by field. A directed table comes first.
// Random phases follow, each with its own virtual node count. A final phase
// uses the largest count and overflows the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_consistent_hash_ring;
  timeunit 1ns;
  timeprecision 1ps;

  import chr_pkg::*;

  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam int         STALL_LIMIT = 2000000;
  localparam int         RAND_ITEMS  = 1280;

  typedef struct packed {
    logic [3:0]  owner;
    status_e     status;
    logic [31:0] hash;
    logic [9:0]  points;
    logic [4:0]  nodes;
  } ring_res_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] b;
    logic       pres;
    logic       last;
    logic [3:0] node;
    logic       typed;
    status_e    st;
    logic [3:0] own;
  } row_t;

  localparam row_t ROWS [22] = '{
    '{ACT_LOOKUP, 8'h00, 1'b0, 1'b1, 4'd0,  1'b1, ST_EMPTY,   4'd0},
    '{ACT_SPARE,  8'hFF, 1'b1, 1'b1, 4'd0,  1'b1, ST_EMPTY,   4'd0},
    '{ACT_LOOKUP, 8'h80, 1'b1, 1'b0, 4'd0,  1'b0, ST_FOUND,   4'd0},
    '{ACT_REMOVE, 8'h00, 1'b0, 1'b0, 4'd9,  1'b0, ST_FOUND,   4'd0},
    '{ACT_LOOKUP, 8'h7F, 1'b1, 1'b1, 4'd0,  1'b1, ST_EMPTY,   4'd0},
    '{ACT_ADD,    8'h41, 1'b1, 1'b1, 4'd0,  1'b1, ST_ADDED,   4'd0},
    '{ACT_ADD,    8'h41, 1'b1, 1'b1, 4'd0,  1'b1, ST_DUP,     4'd0},
    '{ACT_LOOKUP, 8'h00, 1'b1, 1'b1, 4'd0,  1'b1, ST_FOUND,   4'd0},
    '{ACT_ADD,    8'h41, 1'b1, 1'b1, 4'd1,  1'b1, ST_ADDED,   4'd1},
    '{ACT_LOOKUP, 8'hFF, 1'b1, 1'b1, 4'd0,  1'b1, ST_FOUND,   4'd0},
    '{ACT_ADD,    8'hC3, 1'b1, 1'b0, 4'd15, 1'b0, ST_FOUND,   4'd0},
    '{ACT_ADD,    8'h3C, 1'b1, 1'b1, 4'd15, 1'b1, ST_ADDED,   4'd15},
    '{ACT_LOOKUP, 8'h55, 1'b1, 1'b1, 4'd0,  1'b0, ST_FOUND,   4'd0},
    '{ACT_LOOKUP, 8'hAA, 1'b1, 1'b1, 4'd0,  1'b0, ST_FOUND,   4'd0},
    '{ACT_REMOVE, 8'h5A, 1'b1, 1'b1, 4'd7,  1'b1, ST_FAIL,    4'd7},
    '{ACT_REMOVE, 8'h41, 1'b1, 1'b1, 4'd1,  1'b1, ST_REMOVED, 4'd1},
    '{ACT_LOOKUP, 8'h01, 1'b1, 1'b1, 4'd0,  1'b1, ST_FOUND,   4'd15},
    '{ACT_REMOVE, 8'h41, 1'b1, 1'b1, 4'd0,  1'b1, ST_REMOVED, 4'd0},
    '{ACT_REMOVE, 8'hC3, 1'b1, 1'b0, 4'd15, 1'b0, ST_FOUND,   4'd0},
    '{ACT_REMOVE, 8'h3C, 1'b1, 1'b1, 4'd15, 1'b1, ST_REMOVED, 4'd15},
    '{ACT_LOOKUP, 8'h00, 1'b0, 1'b1, 4'd0,  1'b1, ST_EMPTY,   4'd0},
    '{ACT_ADD,    8'hFF, 1'b1, 1'b0, 4'd15, 1'b0, ST_FOUND,   4'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [7:0]  key_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic [3:0]  node_number_i = '0;
  logic        done_o;
  logic [3:0]  owner_node_o;
  logic [2:0]  status_o;
  logic [31:0] key_hash_o;
  logic [9:0]  ring_points_o;
  logic [4:0]  nodes_present_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;

  consistent_hash_ring dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .key_byte_i      (key_byte_i),
    .byte_present_i  (byte_present_i),
    .last_byte_i     (last_byte_i),
    .node_number_i   (node_number_i),
    .done_o          (done_o),
    .owner_node_o    (owner_node_o),
    .status_o        (status_o),
    .key_hash_o      (key_hash_o),
    .ring_points_o   (ring_points_o),
    .nodes_present_o (nodes_present_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the ring
  logic [31:0] slot_hash [RING_DEPTH];
  logic [3:0]  slot_owner [RING_DEPTH];
  logic        slot_used [RING_DEPTH];
  int          used_slots;
  logic [15:0] node_bits;
  logic [31:0] name_hash;
  logic [9:0]  vnodes;

  ring_res_t   pending_results [$];
  int          errors;
  bit          no_idle;
  int          items_sent;
  logic [7:0]  node_names [16][$];

  function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
    return (h ^ {{24{b[7]}}, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] mix_hash(logic [31:0] h);
    logic signed [31:0] s;
    h = h + (h << 13);
    s = h;
    s = s >>> 7;
    h = h ^ s;
    h = h + (h << 3);
    s = h;
    s = s >>> 17;
    h = h ^ s;
    h = h + (h << 5);
    if (h[31]) h = 32'd0 - h;
    return h;
  endfunction

  function automatic logic [31:0] vnode_hash(logic [31:0] base, int idx);
    int digits [$];
    logic [31:0] h;
    h = fold_byte(base, CH_HASH);
    h = fold_byte(h, CH_V);
    h = fold_byte(h, CH_N);
    do begin
      digits.push_front(idx % 10);
      idx = idx / 10;
    end while (idx != 0);
    foreach (digits[k]) h = fold_byte(h, CH_ZERO + 8'(digits[k]));
    return mix_hash(h);
  endfunction

  function automatic int slot_of(logic [31:0] h);
    for (int i = 0; i < RING_DEPTH; i++)
      if (slot_used[i] && slot_hash[i] == h) return i;
    return -1;
  endfunction

  function automatic bit place_point(logic [31:0] h, logic [3:0] owner);
    if (slot_of(h) >= 0) return 1'b1;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_hash[i] = h;
        slot_owner[i] = owner;
        used_slots++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // fold one accepted word into the ring mirror and, on the last byte, queue its result
  task automatic ring_apply(logic [1:0] act, logic [7:0] b, logic pres, logic last,
                            logic [3:0] node);
    ring_res_t r;
    logic [31:0] base;
    int best;
    int least;
    bit ok;
    if (pres) name_hash = fold_byte(name_hash, b);
    if (!last) return;
    base = name_hash;
    name_hash = FNV_BASIS;
    r.hash = mix_hash(base);
    r.owner = '0;
    if (act == ACT_ADD || act == ACT_REMOVE) begin
      r.owner = node;
      if (act == ACT_ADD) begin
        if (node_bits[node]) begin
          r.status = ST_DUP;
        end else begin
          ok = 1'b1;
          node_bits[node] = 1'b1;
          for (int i = 0; i < vnodes; i++)
            if (!place_point(vnode_hash(base, i), node)) ok = 1'b0;
          r.status = ok ? ST_ADDED : ST_FAIL;
        end
      end else if (!node_bits[node]) begin
        r.status = ST_FAIL;
      end else begin
        node_bits[node] = 1'b0;
        for (int i = 0; i < vnodes; i++) begin
          best = slot_of(vnode_hash(base, i));
          if (best >= 0) begin
            slot_used[best] = 1'b0;
            used_slots--;
          end
        end
        r.status = ST_REMOVED;
      end
    end else begin
      best = -1;
      least = -1;
      for (int j = 0; j < RING_DEPTH; j++) begin
        if (!slot_used[j]) continue;
        if (least < 0 || $signed(slot_hash[j]) < $signed(slot_hash[least])) least = j;
        if ($signed(slot_hash[j]) >= $signed(r.hash) &&
            (best < 0 || $signed(slot_hash[j]) < $signed(slot_hash[best]))) best = j;
      end
      if (best < 0) best = least;
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_FOUND;
        r.owner = slot_owner[best];
      end
    end
    r.points = 10'(used_slots);
    r.nodes = 5'($countones(node_bits));
    pending_results.push_back(r);
  endtask

  // drive one word and hold it until the block takes it
  task automatic send_word(logic [1:0] act, logic [7:0] b, logic pres, logic last,
                           logic [3:0] node);
    while (!no_idle && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    action_i <= act;
    key_byte_i <= b;
    byte_present_i <= pres;
    last_byte_i <= last;
    node_number_i <= node;
    do @(posedge clk_i); while (busy);
    ring_apply(act, b, pres, last, node);
    items_sent++;
  endtask

  task automatic send_string(logic [1:0] act, logic [7:0] s [$], logic [3:0] node);
    logic p;
    foreach (s[k]) begin
      if ($urandom_range(19) == 0)
        send_word(2'($urandom), 8'($urandom), 1'b0, 1'b0, 4'($urandom));
      send_word($urandom_range(9) == 0 ? 2'($urandom) : act, s[k], 1'b1,
                1'b0, 4'($urandom));
    end
    p = ($urandom_range(3) == 0);
    send_word(act, 8'($urandom), p, 1'b1, node);
  endtask

  // drain the block, then write the virtual node count
  task automatic set_vnodes(logic [9:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    vnodes = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_string();
    logic [7:0] s [$];
    logic [3:0] node;
    int pick;
    int len;
    pick = $urandom_range(99);
    node = 4'($urandom);
    if (pick < 65) begin
      len = $urandom_range(5);
      repeat (len) s.push_back(8'($urandom));
      send_string($urandom_range(7) == 0 ? ACT_SPARE : ACT_LOOKUP, s, node);
    end else begin
      if ($urandom_range(4) == 0) begin
        len = $urandom_range(1, 3);
        repeat (len) s.push_back(8'($urandom));
      end else begin
        s = node_names[node];
      end
      send_string(pick < 83 ? ACT_ADD : ACT_REMOVE, s, node);
    end
  endtask

  always @(posedge clk_i) begin
    ring_res_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (owner_node_o !== e.owner) begin
          $error("owner_node: expected %0d, got %0d", e.owner, owner_node_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (key_hash_o !== e.hash) begin
          $error("key_hash: expected %h, got %h", e.hash, key_hash_o);
          errors++;
        end
        if (ring_points_o !== e.points) begin
          $error("ring_points: expected %0d, got %0d", e.points, ring_points_o);
          errors++;
        end
        if (nodes_present_o !== e.nodes) begin
          $error("nodes_present: expected %0d, got %0d", e.nodes, nodes_present_o);
          errors++;
        end
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_consistent_hash_ring failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] s [$];
    int phase;
    int fresh;
    for (int i = 0; i < RING_DEPTH; i++) slot_used[i] = 1'b0;
    used_slots = 0;
    node_bits = '0;
    name_hash = FNV_BASIS;
    vnodes = VPN_RESET;
    errors = 0;
    items_sent = 0;
    no_idle = 1'b0;
    for (int n = 0; n < 16; n++)
      repeat ($urandom_range(1, 3)) node_names[n].push_back(8'($urandom));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // hold off while the ring is cleared after reset
    do @(posedge clk_i); while (busy);

    foreach (ROWS[k]) begin
      send_word(ROWS[k].act, ROWS[k].b, ROWS[k].pres, ROWS[k].last, ROWS[k].node);
      if (ROWS[k].last && ROWS[k].typed) begin
        pending_results[$].status = ROWS[k].st;
        pending_results[$].owner = ROWS[k].own;
      end
    end
    send_word(ACT_LOOKUP, 8'h00, 1'b0, 1'b1, 4'd0);

    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent >= 60 + phase * 170) begin
        set_vnodes(phase % 4 == 1 ? 10'd0 : 10'($urandom_range(1, 4)));
        phase++;
        no_idle = (phase == 3);
      end
      random_string();
    end

    // overflow the ring with the largest virtual node count
    set_vnodes(10'd1023);
    no_idle = 1'b0;
    fresh = 0;
    for (int n = 0; n < 16; n++) if (!node_bits[n]) fresh = n;
    s = node_names[fresh];
    send_string(ACT_ADD, s, 4'(fresh));
    repeat (4) random_string();

    @(negedge clk_i);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_consistent_hash_ring passed");
    end else begin
      $display("tb_consistent_hash_ring failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/chr_pkg.sv
rtl/chr_dp.sv
rtl/chr_ctrl.sv
rtl/consistent_hash_ring.sv
sim/tb_consistent_hash_ring.sv
